@@ hdl/rotation_matrix_to_quaternion_assert.svh @@
// Assertion helpers shared by rmq_fifo and rmq_back.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RMQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rmq assertion failed");

// Next-cycle implication, disabled during reset.
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rmq assertion failed");

`endif

@@ hdl/rmq_pkg.sv @@
package rmq_pkg;

	// branch code reported with each result
	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

	// log2 of the entries in each of the two queues
	localparam int QUEUE_DEPTH_LOG2 = 2;

endpackage

@@ hdl/rmq_fifo.sv @@
`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_fifo #(
	parameter int WIDTH      = 8,
	parameter int DEPTH_LOG2 = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int DEPTH = 2 ** DEPTH_LOG2;

	logic [WIDTH-1:0]    mem_q [0:DEPTH-1];
	logic [DEPTH_LOG2:0] wr_q;
	logic [DEPTH_LOG2:0] rd_q;
	logic [DEPTH_LOG2:0] count;
	logic                do_push;
	logic                do_pop;

	assign count   = wr_q - rd_q;
	assign full    = (count == (DEPTH_LOG2+1)'(DEPTH));
	assign empty   = (count == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q[DEPTH_LOG2-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q[DEPTH_LOG2-1:0]] <= wdata;
		end
	end

	`RMQ_ASSERT_NOW(a_fifo_bound, clk, arst_n, 1'b1, count <= (DEPTH_LOG2+1)'(DEPTH))
	`RMQ_ASSERT_NEXT(a_fifo_fill, clk, arst_n, do_push && !do_pop, count == $past(count) + 1'b1)
	`RMQ_ASSERT_NEXT(a_fifo_drain, clk, arst_n, do_pop && !do_push, count == $past(count) - 1'b1)

endmodule

@@ hdl/rmq_front.sv @@
module rmq_front #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 30
) (
	input  logic signed [DATA_WIDTH-1:0] m00,
	input  logic signed [DATA_WIDTH-1:0] m01,
	input  logic signed [DATA_WIDTH-1:0] m02,
	input  logic signed [DATA_WIDTH-1:0] m10,
	input  logic signed [DATA_WIDTH-1:0] m11,
	input  logic signed [DATA_WIDTH-1:0] m12,
	input  logic signed [DATA_WIDTH-1:0] m20,
	input  logic signed [DATA_WIDTH-1:0] m21,
	input  logic signed [DATA_WIDTH-1:0] m22,
	output rmq_pkg::branch_t             branch,
	output logic                         radpos,
	output logic [DATA_WIDTH:0]          rad,
	output logic [2:0]                   neg,
	output logic [2:0][DATA_WIDTH:0]     mag
);

	localparam int W = DATA_WIDTH;

	logic signed [W+1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [W+1:0] one, trace, r;
	logic signed [W+1:0] n [3];

	assign e00 = (W+2)'(m00);
	assign e01 = (W+2)'(m01);
	assign e02 = (W+2)'(m02);
	assign e10 = (W+2)'(m10);
	assign e11 = (W+2)'(m11);
	assign e12 = (W+2)'(m12);
	assign e20 = (W+2)'(m20);
	assign e21 = (W+2)'(m21);
	assign e22 = (W+2)'(m22);
	assign one   = (W+2)'(1) <<< FRAC_BITS;
	assign trace = one + e00 + e11 + e22;

	// numerators are kept in component order with the branch's own one left out
	always_comb begin
		if (!trace[W+1] && trace != '0) begin
			branch = rmq_pkg::BR_TRACE;
			r      = trace;
			n[0]   = e12 - e21;
			n[1]   = e20 - e02;
			n[2]   = e01 - e10;
		end else if (e00 > e11 && e00 > e22) begin
			branch = rmq_pkg::BR_X;
			r      = one + e00 - e11 - e22;
			n[0]   = e10 + e01;
			n[1]   = e20 + e02;
			n[2]   = e12 - e21;
		end else if (e11 > e22) begin
			branch = rmq_pkg::BR_Y;
			r      = one + e11 - e00 - e22;
			n[0]   = e10 + e01;
			n[1]   = e21 + e12;
			n[2]   = e20 - e02;
		end else begin
			branch = rmq_pkg::BR_Z;
			r      = one + e22 - e00 - e11;
			n[0]   = e20 + e02;
			n[1]   = e21 + e12;
			n[2]   = e01 - e10;
		end
		for (int k = 0; k < 3; k++) begin
			neg[k] = n[k][W+1];
			mag[k] = n[k][W+1] ? (W+1)'(-n[k]) : n[k][W:0];
		end
	end

	assign radpos = !r[W+1] && r != '0;
	assign rad    = r[W:0];

endmodule

@@ hdl/rmq_back.sv @@
`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_back #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 30
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_pop,
	input  rmq_pkg::branch_t            in_branch,
	input  logic                        in_radpos,
	input  logic [DATA_WIDTH:0]         in_rad,
	input  logic [2:0]                  in_neg,
	input  logic [2:0][DATA_WIDTH:0]    in_mag,
	output logic                        out_push,
	input  logic                        out_full,
	output logic [3:0][DATA_WIDTH-1:0]  out_quat,
	output rmq_pkg::branch_t            out_branch
);

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int XW = W + 1 + F;       // radicand width
	localparam int SW = (XW + 1) / 2;    // root width
	localparam int XP = 2 * SW;
	localparam int RW = SW + 2;          // partial remainder width
	localparam int DW = W + 1 + F;       // dividend width
	localparam int QW = DW;

	logic en;

	// square root stages
	logic                   sq_v_s    [0:SW];
	logic [RW-1:0]          sq_rem_s  [0:SW];
	logic [SW-1:0]          sq_root_s [0:SW];
	logic [XP-1:0]          sq_x_s    [0:SW];
	rmq_pkg::branch_t       sq_br_s   [0:SW];
	logic                   sq_zr_s   [0:SW];
	logic [2:0]             sq_neg_s  [0:SW];
	logic [2:0][W:0]        sq_mag_s  [0:SW];

	// divider stages, three lanes sharing one divisor
	logic                   dv_v_s    [0:QW];
	logic [SW-1:0]          dv_root_s [0:QW];
	rmq_pkg::branch_t       dv_br_s   [0:QW];
	logic                   dv_zr_s   [0:QW];
	logic [2:0]             dv_neg_s  [0:QW];
	logic [2:0][RW-1:0]     dv_rem_s  [0:QW];
	logic [2:0][DW-1:0]     dv_dvd_s  [0:QW];
	logic [2:0][QW-1:0]     dv_quo_s  [0:QW];

	assign en       = !(dv_v_s[QW] && out_full);
	assign in_pop   = en && in_valid;
	assign out_push = dv_v_s[QW] && !out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_x_s[0]    <= XP'({in_rad, {F{1'b0}}});
			sq_br_s[0]   <= in_branch;
			sq_zr_s[0]   <= !in_radpos;
			sq_neg_s[0]  <= in_neg;
			sq_mag_s[0]  <= in_mag;
		end
	end

	for (genvar i = 1; i <= SW; i++) begin : g_sq
		logic [RW-1:0] rem2;
		logic [RW-1:0] trial;
		logic          ge;

		assign rem2  = {sq_rem_s[i-1][RW-3:0], sq_x_s[i-1][XP-1 -: 2]};
		assign trial = {sq_root_s[i-1], 2'b01};
		assign ge    = rem2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[i] <= 1'b0;
			end else if (en) begin
				sq_v_s[i] <= sq_v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[i]  <= ge ? rem2 - trial : rem2;
				sq_root_s[i] <= {sq_root_s[i-1][SW-2:0], ge};
				sq_x_s[i]    <= sq_x_s[i-1] << 2;
				sq_br_s[i]   <= sq_br_s[i-1];
				sq_zr_s[i]   <= sq_zr_s[i-1];
				sq_neg_s[i]  <= sq_neg_s[i-1];
				sq_mag_s[i]  <= sq_mag_s[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[SW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_root_s[0] <= sq_root_s[SW];
			dv_br_s[0]   <= sq_br_s[SW];
			dv_zr_s[0]   <= sq_zr_s[SW];
			dv_neg_s[0]  <= sq_neg_s[SW];
			for (int k = 0; k < 3; k++) begin
				dv_rem_s[0][k] <= '0;
				dv_dvd_s[0][k] <= {sq_mag_s[SW][k], {F{1'b0}}};
				dv_quo_s[0][k] <= '0;
			end
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_dv
		logic [RW-1:0]      den;
		logic [2:0][RW-1:0] rem2;
		logic [2:0]         ge;

		assign den = RW'({dv_root_s[j-1], 1'b0});

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				rem2[k] = {dv_rem_s[j-1][k][RW-2:0], dv_dvd_s[j-1][k][DW-1]};
				ge[k]   = rem2[k] >= den;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else if (en) begin
				dv_v_s[j] <= dv_v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_root_s[j] <= dv_root_s[j-1];
				dv_br_s[j]   <= dv_br_s[j-1];
				dv_zr_s[j]   <= dv_zr_s[j-1];
				dv_neg_s[j]  <= dv_neg_s[j-1];
				for (int k = 0; k < 3; k++) begin
					dv_rem_s[j][k] <= ge[k] ? rem2[k] - den : rem2[k];
					dv_dvd_s[j][k] <= dv_dvd_s[j-1][k] << 1;
					dv_quo_s[j][k] <= {dv_quo_s[j-1][k][QW-2:0], ge[k]};
				end
			end
		end
	end

	// saturation and placement of the own component
	localparam logic [QW-1:0] MAX_POS = {{(F+2){1'b0}}, {(W-1){1'b1}}};
	localparam logic [QW-1:0] MAX_NEG = {{(F+1){1'b0}}, 1'b1, {(W-1){1'b0}}};

	logic [2:0][W-1:0] other;
	logic [W-1:0]      own;
	logic [QW-1:0]     own_full;

	assign own_full = QW'(dv_root_s[QW][SW-1:1]);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (dv_neg_s[QW][k]) begin
				other[k] = (dv_quo_s[QW][k] > MAX_NEG) ? {1'b1, {(W-1){1'b0}}}
					: W'(~dv_quo_s[QW][k][W-1:0] + 1'b1);
			end else begin
				other[k] = (dv_quo_s[QW][k] > MAX_POS) ? {1'b0, {(W-1){1'b1}}}
					: dv_quo_s[QW][k][W-1:0];
			end
		end
		own = (own_full > MAX_POS) ? {1'b0, {(W-1){1'b1}}} : own_full[W-1:0];
		case (dv_br_s[QW])
			rmq_pkg::BR_TRACE: out_quat = {own, other[2], other[1], other[0]};
			rmq_pkg::BR_X:     out_quat = {other[2], other[1], other[0], own};
			rmq_pkg::BR_Y:     out_quat = {other[2], other[1], own, other[0]};
			rmq_pkg::BR_Z:     out_quat = {other[2], own, other[1], other[0]};
			default:           out_quat = '0;
		endcase
		if (dv_zr_s[QW]) begin
			out_quat = '0;
		end
	end

	assign out_branch = dv_br_s[QW];

	`RMQ_ASSERT_NOW(a_back_push, clk, arst_n, out_push, !out_full && dv_v_s[QW])
	`RMQ_ASSERT_NEXT(a_back_hold, clk, arst_n, !en, dv_v_s[QW] && $stable(dv_quo_s[QW]))
	`RMQ_ASSERT_NEXT(a_back_flow, clk, arst_n, en && sq_v_s[SW], dv_v_s[0])

endmodule

@@ hdl/rotation_matrix_to_quaternion.sv @@
// Channel   | Transfer when     | Payload
// ----------+-------------------+-------------------------------------------
// input     | push && !full     | m00 m01 m02 m10 m11 m12 m20 m21 m22
// result    | pop && !empty     | quat_x quat_y quat_z quat_w branch_taken
//
// One matrix per cycle is taken when the result side keeps up; the pipeline
// stalls as a whole only while its last stage holds a result and the output
// queue is full. The back end has SW = (DATA_WIDTH+FRAC_BITS+2)/2 root
// stages and QW = DATA_WIDTH+FRAC_BITS+1 divide stages: a bit-per-stage
// square root and a three-lane divider.
// Reset clears queue pointers and stage valid bits only; no clearing pass.
module rotation_matrix_to_quaternion #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 30
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [DATA_WIDTH-1:0] m00,
	input  logic signed [DATA_WIDTH-1:0] m01,
	input  logic signed [DATA_WIDTH-1:0] m02,
	input  logic signed [DATA_WIDTH-1:0] m10,
	input  logic signed [DATA_WIDTH-1:0] m11,
	input  logic signed [DATA_WIDTH-1:0] m12,
	input  logic signed [DATA_WIDTH-1:0] m20,
	input  logic signed [DATA_WIDTH-1:0] m21,
	input  logic signed [DATA_WIDTH-1:0] m22,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [DATA_WIDTH-1:0] quat_x,
	output logic signed [DATA_WIDTH-1:0] quat_y,
	output logic signed [DATA_WIDTH-1:0] quat_z,
	output logic signed [DATA_WIDTH-1:0] quat_w,
	output logic [1:0]                   branch_taken
);

	localparam int W     = DATA_WIDTH;
	localparam int MID_W = 2 + 1 + (W + 1) + 3 + 3 * (W + 1);
	localparam int OUT_W = 2 + 4 * W;

	// front: classify and form radicand and numerators
	rmq_pkg::branch_t f_branch;
	logic             f_radpos;
	logic [W:0]       f_rad;
	logic [2:0]       f_neg;
	logic [2:0][W:0]  f_mag;

	rmq_front #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.m00    (m00),
		.m01    (m01),
		.m02    (m02),
		.m10    (m10),
		.m11    (m11),
		.m12    (m12),
		.m20    (m20),
		.m21    (m21),
		.m22    (m22),
		.branch (f_branch),
		.radpos (f_radpos),
		.rad    (f_rad),
		.neg    (f_neg),
		.mag    (f_mag)
	);

	// queue between front and back
	logic [MID_W-1:0] mid_wdata;
	logic [MID_W-1:0] mid_rdata;
	logic             mid_empty;
	logic             mid_pop;

	assign mid_wdata = {f_branch, f_radpos, f_rad, f_neg, f_mag};

	rmq_fifo #(
		.WIDTH      (MID_W),
		.DEPTH_LOG2 (rmq_pkg::QUEUE_DEPTH_LOG2)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (mid_wdata),
		.pop    (mid_pop),
		.empty  (mid_empty),
		.rdata  (mid_rdata)
	);

	rmq_pkg::branch_t b_branch;
	logic             b_radpos;
	logic [W:0]       b_rad;
	logic [2:0]       b_neg;
	logic [2:0][W:0]  b_mag;

	assign b_branch = rmq_pkg::branch_t'(mid_rdata[MID_W-1 -: 2]);
	assign {b_radpos, b_rad, b_neg, b_mag} = mid_rdata[MID_W-3:0];

	// back: square root then division, one stage per result bit
	logic             r_push;
	logic             r_full;
	logic [3:0][W-1:0] r_quat;
	rmq_pkg::branch_t r_branch;

	rmq_back #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (!mid_empty),
		.in_pop     (mid_pop),
		.in_branch  (b_branch),
		.in_radpos  (b_radpos),
		.in_rad     (b_rad),
		.in_neg     (b_neg),
		.in_mag     (b_mag),
		.out_push   (r_push),
		.out_full   (r_full),
		.out_quat   (r_quat),
		.out_branch (r_branch)
	);

	// output queue decouples the pipeline from the consumer
	logic [OUT_W-1:0] out_rdata;

	rmq_fifo #(
		.WIDTH      (OUT_W),
		.DEPTH_LOG2 (rmq_pkg::QUEUE_DEPTH_LOG2)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (r_push),
		.full   (r_full),
		.wdata  ({r_branch, r_quat}),
		.pop    (pop),
		.empty  (empty),
		.rdata  (out_rdata)
	);

	assign branch_taken = out_rdata[OUT_W-1 -: 2];
	assign quat_w       = out_rdata[4*W-1 -: W];
	assign quat_z       = out_rdata[3*W-1 -: W];
	assign quat_y       = out_rdata[2*W-1 -: W];
	assign quat_x       = out_rdata[W-1:0];

endmodule

@@ verif/rotation_matrix_to_quaternion_tb.sv @@
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_tb;

	localparam int DW   = 32;
	localparam int FRAC = 30;
	localparam int ONE  = 1 << FRAC;
	localparam int N_RANDOM_PER_PHASE = 425;
	// margin covers the pipeline depth of the block plus queues
	localparam int DRAIN_CYCLES = 300;

	typedef logic signed [DW-1:0] matrix_t [9];

	typedef struct {
		logic signed [DW-1:0] x, y, z, w;
		rmq_pkg::branch_t     br;
	} quat_t;

	typedef struct {
		matrix_t m;
		bit      known;   // expected value typed in below
		quat_t   q;
	} vector_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic signed [DW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic                 empty;
	logic                 pop;
	logic signed [DW-1:0] quat_x, quat_y, quat_z, quat_w;
	logic [1:0]           branch_taken;

	quat_t   pending_quats[$];
	vector_t directed[$];
	int      n_errors = 0;
	int      n_sent = 0;
	int      n_checked = 0;
	int      n_branch[4] = '{0, 0, 0, 0};
	int      send_gap_pct = 0;
	int      pop_stall_pct = 0;

	rotation_matrix_to_quaternion u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.m00          (m00),
		.m01          (m01),
		.m02          (m02),
		.m10          (m10),
		.m11          (m11),
		.m12          (m12),
		.m20          (m20),
		.m21          (m21),
		.m22          (m22),
		.empty        (empty),
		.pop          (pop),
		.quat_x       (quat_x),
		.quat_y       (quat_y),
		.quat_z       (quat_z),
		.quat_w       (quat_w),
		.branch_taken (branch_taken)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Shepperd conversion in 128-bit exact arithmetic. Trace test is strict;
	// a tie on the diagonal falls to the later branch.
	function automatic quat_t shepperd_quat(input matrix_t m);
		logic signed [127:0] e[9];
		logic signed [127:0] unity, tr, rad, s, cand;
		logic signed [127:0] num[4], comp[4];
		logic signed [DW-1:0] sat[4];
		int own;
		quat_t r;
		for (int i = 0; i < 9; i++)
			e[i] = m[i];
		unity = 128'sd1 <<< FRAC;
		tr = unity + e[0] + e[4] + e[8];
		num = '{default: 0};
		if (tr > 0) begin
			r.br = rmq_pkg::BR_TRACE; own = 3; rad = tr;
			num[0] = e[5] - e[7];
			num[1] = e[6] - e[2];
			num[2] = e[1] - e[3];
		end else if (e[0] > e[4] && e[0] > e[8]) begin
			r.br = rmq_pkg::BR_X; own = 0; rad = unity + e[0] - e[4] - e[8];
			num[1] = e[3] + e[1];
			num[2] = e[6] + e[2];
			num[3] = e[5] - e[7];
		end else if (e[4] > e[8]) begin
			r.br = rmq_pkg::BR_Y; own = 1; rad = unity + e[4] - e[0] - e[8];
			num[0] = e[3] + e[1];
			num[2] = e[7] + e[5];
			num[3] = e[6] - e[2];
		end else begin
			r.br = rmq_pkg::BR_Z; own = 2; rad = unity + e[8] - e[0] - e[4];
			num[0] = e[6] + e[2];
			num[1] = e[7] + e[5];
			num[3] = e[1] - e[3];
		end
		if (rad <= 0) begin
			comp = '{default: 0};
		end else begin
			// bitwise integer root of rad in the fixed-point format
			s = 0;
			for (int b = 40; b >= 0; b--) begin
				cand = s | (128'sd1 <<< b);
				if (cand * cand <= (rad <<< FRAC))
					s = cand;
			end
			for (int k = 0; k < 4; k++)
				comp[k] = (k == own) ? (s >>> 1) : ((num[k] <<< FRAC) / (s <<< 1));
		end
		for (int k = 0; k < 4; k++) begin
			if (comp[k] > 128'sd2147483647)
				sat[k] = 32'sh7fff_ffff;
			else if (comp[k] < -128'sd2147483648)
				sat[k] = 32'sh8000_0000;
			else
				sat[k] = comp[k][DW-1:0];
		end
		r.x = sat[0];
		r.y = sat[1];
		r.z = sat[2];
		r.w = sat[3];
		return r;
	endfunction

	function automatic vector_t row(input int a00, a01, a02, a10, a11, a12,
			a20, a21, a22, input bit known = 0, input int qx = 0, input int qy = 0,
			input int qz = 0, input int qw = 0,
			input rmq_pkg::branch_t br = rmq_pkg::BR_TRACE);
		vector_t v;
		v.m = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};
		v.known = known;
		v.q = '{qx, qy, qz, qw, br};
		return v;
	endfunction

	// Random proper rotation built from a normalized random quaternion.
	function automatic matrix_t random_rotation();
		real qx, qy, qz, qw, nrm;
		real r[9];
		matrix_t m;
		qx = real'(int'($urandom_range(0, 2000)) - 1000);
		qy = real'(int'($urandom_range(0, 2000)) - 1000);
		qz = real'(int'($urandom_range(0, 2000)) - 1000);
		qw = real'(int'($urandom_range(0, 2000)) - 1000) + 0.001;
		nrm = $sqrt(qx*qx + qy*qy + qz*qz + qw*qw);
		qx = qx / nrm; qy = qy / nrm; qz = qz / nrm; qw = qw / nrm;
		r[0] = 1.0 - 2.0*(qy*qy + qz*qz);
		r[1] = 2.0*(qx*qy - qz*qw);
		r[2] = 2.0*(qx*qz + qy*qw);
		r[3] = 2.0*(qx*qy + qz*qw);
		r[4] = 1.0 - 2.0*(qx*qx + qz*qz);
		r[5] = 2.0*(qy*qz - qx*qw);
		r[6] = 2.0*(qx*qz - qy*qw);
		r[7] = 2.0*(qy*qz + qx*qw);
		r[8] = 1.0 - 2.0*(qx*qx + qy*qy);
		for (int i = 0; i < 9; i++)
			m[i] = $rtoi(r[i] * 1073741824.0);
		return m;
	endfunction

	// Present one matrix and hold it until the transfer; push stays high
	// afterwards so back-to-back transfers need no extra edge.
	task automatic send_matrix(input matrix_t m);
		push <= 1'b1;
		{m00, m01, m02} <= {m[0], m[1], m[2]};
		{m10, m11, m12} <= {m[3], m[4], m[5]};
		{m20, m21, m22} <= {m[6], m[7], m[8]};
		do
			@(posedge clk);
		while (full);
		pending_quats.push_back(shepperd_quat(m));
		n_sent++;
	endtask

	// Random gap after a transfer, per the current phase.
	task automatic sender_gap();
		if (send_gap_pct > 0 && int'($urandom_range(0, 99)) < send_gap_pct) begin
			push <= 1'b0;
			do
				@(posedge clk);
			while (int'($urandom_range(0, 99)) < send_gap_pct);
		end
	endtask

	task automatic wait_drained();
		while (pending_quats.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random stall, compare each transfer with the oldest
	// expectation.
	always @(posedge clk or negedge arst_n) begin
		quat_t exp_q;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (pending_quats.size() == 0) begin
					$error("unexpected result transfer x=%0d y=%0d z=%0d w=%0d br=%0d",
						quat_x, quat_y, quat_z, quat_w, branch_taken);
					n_errors++;
				end else begin
					exp_q = pending_quats.pop_front();
					n_checked++;
					n_branch[exp_q.br]++;
					if (quat_x !== exp_q.x) begin
						$error("quat_x exp %0d got %0d", exp_q.x, quat_x);
						n_errors++;
					end
					if (quat_y !== exp_q.y) begin
						$error("quat_y exp %0d got %0d", exp_q.y, quat_y);
						n_errors++;
					end
					if (quat_z !== exp_q.z) begin
						$error("quat_z exp %0d got %0d", exp_q.z, quat_z);
						n_errors++;
					end
					if (quat_w !== exp_q.w) begin
						$error("quat_w exp %0d got %0d", exp_q.w, quat_w);
						n_errors++;
					end
					if (branch_taken !== exp_q.br) begin
						$error("branch_taken exp %0d got %0d", exp_q.br, branch_taken);
						n_errors++;
					end
				end
			end
			pop <= (int'($urandom_range(0, 99)) >= pop_stall_pct);
		end
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		matrix_t m;
		int kind;
		push = 1'b0;
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: the five exact identity / half-turn / zero-matrix cases are typed in,
		// the rest (extremes, ties, saturation) go through the predictor.
		directed.push_back(row(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1, 0, 0, 0, ONE,
			rmq_pkg::BR_TRACE));
		// trace exactly zero: half turns about each axis
		directed.push_back(row(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE, 1, ONE, 0, 0, 0,
			rmq_pkg::BR_X));
		directed.push_back(row(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE, 1, 0, ONE, 0, 0,
			rmq_pkg::BR_Y));
		directed.push_back(row(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE, 1, 0, 0, ONE, 0,
			rmq_pkg::BR_Z));
		directed.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, ONE / 2,
			rmq_pkg::BR_TRACE));
		directed.push_back(row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		directed.push_back(row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
		directed.push_back(row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));
		// trace one LSB above zero with huge off-diagonals: saturates both ways
		directed.push_back(row(0, 32'h7fffffff, 32'h80000000, 32'h80000000, 0,
			32'h7fffffff, 32'h7fffffff, 32'h80000000, -ONE + 1));
		directed.push_back(row(0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0,
			32'h80000000, 32'h80000000, 32'h7fffffff, -ONE + 1));
		// diagonal ties with negative trace
		directed.push_back(row(-ONE / 2, 5, -7, 9, -ONE / 2, 11, -13, 15, -ONE / 2));
		directed.push_back(row(-ONE / 3, 1, 2, 3, -ONE / 3, 4, 5, 6, -ONE));
		directed.push_back(row(-ONE / 3, 1, 2, 3, -ONE, 4, 5, 6, -ONE / 3));
		directed.push_back(row(32'h7fffffff, 100, -100, 200, 32'h80000000, -300, 400,
			-500, 32'h80000000));
		directed.push_back(row(-ONE, 123456, -654321, 777, -ONE, -999, 31337, 4242, -ONE));

		foreach (directed[i]) begin
			send_matrix(directed[i].m);
			if (directed[i].known) begin
				pending_quats.pop_back();
				pending_quats.push_back(directed[i].q);
			end
		end
		push <= 1'b0;
		@(posedge clk);
		wait_drained();

		// Random phases: free flow, sender idle, receiver stall, both.
		for (int phase = 0; phase < 4; phase++) begin
			send_gap_pct  = (phase == 1) ? 73 : (phase == 3) ? 24 : 0;
			pop_stall_pct = (phase == 2) ? 73 : (phase == 3) ? 24 : 0;
			for (int n = 0; n < N_RANDOM_PER_PHASE; n++) begin
				kind = $urandom_range(0, 9);
				if (kind < 6) begin
					m = random_rotation();
				end else if (kind < 8) begin
					m = random_rotation();
					for (int i = 0; i < 9; i++)
						m[i] = m[i] + (int'($urandom_range(0, 2047)) - 1024);
				end else begin
					for (int i = 0; i < 9; i++)
						m[i] = $urandom;
				end
				send_matrix(m);
				// hold off once mid-phase until everything is back
				if (phase == 0 && n == N_RANDOM_PER_PHASE / 2) begin
					push <= 1'b0;
					wait_drained();
				end else begin
					sender_gap();
				end
			end
		end
		push <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d matrices, %0d results checked", n_sent, n_checked);
		$display("branches trace/x/y/z: %0d/%0d/%0d/%0d",
			n_branch[0], n_branch[1], n_branch[2], n_branch[3]);
		if (n_errors == 0 && pending_quats.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
